/* hw/rtl/packet_dedup_hash_window_top_assert.svh */
// Assertion macros for the duplicate filter.
// Included by the top level; depends on nothing else.
`ifndef PACKET_DEDUP_HASH_WINDOW_TOP_ASSERT_SVH
`define PACKET_DEDUP_HASH_WINDOW_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under a synchronous active-low reset.
`define PDHW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under a synchronous active-low reset.
`define PDHW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDHW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PDHW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/pdhw_pkg.sv */
// Shared types and constants of the duplicate filter.
// Used by the table, the compare unit and the top level; no dependencies.
package pdhw_pkg;

    localparam logic [31:0] HASH_SEED     = 32'd5381;
    localparam logic [31:0] WINDOW_RESET  = 32'd25000;

    typedef struct packed {
        logic        live;
        logic [31:0] hash;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic live_after;
        logic expire;
        logic match;
    } t_cmp_res;

endpackage

/* hw/rtl/packet_dedup_hash_window_top.sv */
// Duplicate-packet filter: djb2 hash of a byte stream checked against a timed ring.
// Depends on pdhw_pkg, pdhw_table, pdhw_cmp and the assertion header.
//
// Usage: bytes of the station name and then the payload arrive on the input
// channel (i_in_valid / o_in_ready) with i_last_byte marking the final beat and
// i_now_ms giving the time of that final beat. Each ordinary byte is folded into
// the hash in the cycle it is accepted, so such bytes go at one per cycle while
// o_in_ready is high. A last byte starts a sweep of the entry table through
// the single compare unit, one slot per cycle, during which o_in_ready stays
// low; each slot is read through the registered read port of the table memory.
// One result beat (o_is_duplicate, o_evicted_live) per packet
// appears on o_out_valid / i_out_ready and is held in an output register, so
// the next packet's bytes are taken while the result waits. If the receiver
// stalls and a second result is ready, the block holds it and takes no input.
// Reset empties the table (a fill count marks written slots, no clearing pass),
// reseeds the hash and sets the window to 25000 ms. i_cfg_we writes the window
// in the same cycle; it is meant to be written only while the block is idle.
`include "packet_dedup_hash_window_top_assert.svh"

module packet_dedup_hash_window_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_duplicate,
    output logic        o_evicted_live,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]    r_state;
    logic [31:0]   r_window;
    logic [31:0]   r_run_hash;
    logic [31:0]   r_key;
    logic [31:0]   r_now;
    logic [CW-1:0] r_rd_idx;
    logic          r_ev_valid;
    logic [AW-1:0] r_ev_idx;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_fill;
    logic          r_dup;
    logic          r_head_live;
    logic          r_out_valid;
    logic          r_out_dup;
    logic          r_out_evict;

    logic             in_fire;
    logic [31:0]      next_hash;
    logic             rd_more;
    logic             written;
    logic             out_free;
    logic             finish_go;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    pdhw_pkg::t_entry mem_wdata;
    pdhw_pkg::t_entry mem_rdata;
    pdhw_pkg::t_cmp_res cmp_res;
    logic [AW-1:0]    head_next;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign next_hash  = {r_run_hash[26:0], 5'b0} + r_run_hash + {24'b0, i_data_byte};
    assign rd_more    = (r_rd_idx < CW'(TABLE_DEPTH));
    assign written    = ({1'b0, r_ev_idx} < r_fill);
    assign out_free   = !r_out_valid || i_out_ready;
    assign finish_go  = (r_state == ST_FINISH) && out_free;
    assign head_next  = (r_head == AW'(TABLE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    pdhw_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    pdhw_cmp u_cmp (
        .i_entry   (mem_rdata),
        .i_written (written),
        .i_now_ms  (r_now),
        .i_window  (r_window),
        .i_key     (r_key),
        .o_res     (cmp_res)
    );

    // Write port: clear the live flag of an expired slot during the sweep,
    // or store the new hash at the head once the sweep has finished.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ev_idx;
        mem_wdata = mem_rdata;
        if (r_state == ST_SWEEP && r_ev_valid && cmp_res.expire) begin
            mem_we         = 1'b1;
            mem_wdata.live = 1'b0;
        end else if (finish_go && !r_dup) begin
            mem_we          = 1'b1;
            mem_waddr       = r_head;
            mem_wdata.live  = 1'b1;
            mem_wdata.hash  = r_key;
            mem_wdata.stamp = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= pdhw_pkg::WINDOW_RESET;
            r_run_hash  <= pdhw_pkg::HASH_SEED;
            r_rd_idx    <= '0;
            r_ev_valid  <= 1'b0;
            r_ev_idx    <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_dup       <= 1'b0;
            r_head_live <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_last_byte) begin
                            r_run_hash  <= pdhw_pkg::HASH_SEED;
                            r_rd_idx    <= '0;
                            r_ev_valid  <= 1'b0;
                            r_dup       <= 1'b0;
                            r_head_live <= 1'b0;
                            r_state     <= ST_SWEEP;
                        end else begin
                            r_run_hash <= next_hash;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_ev_valid <= rd_more;
                    r_ev_idx   <= r_rd_idx[AW-1:0];
                    if (rd_more) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_ev_valid) begin
                        if (cmp_res.match) begin
                            r_dup <= 1'b1;
                        end
                        if (r_ev_idx == r_head) begin
                            r_head_live <= cmp_res.live_after;
                        end
                        if (r_ev_idx == AW'(TABLE_DEPTH - 1)) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        if (!r_dup) begin
                            r_head <= head_next;
                            if (r_fill != CW'(TABLE_DEPTH)) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_last_byte) begin
            r_key <= next_hash;
            r_now <= i_now_ms;
        end
        if (finish_go) begin
            r_out_dup   <= r_dup;
            r_out_evict <= !r_dup && r_head_live;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_duplicate = r_out_dup;
    assign o_evicted_live = r_out_evict;

    `PDHW_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(TABLE_DEPTH),
        "fill count beyond table depth")
    `PDHW_ASSERT_IMP(a_dup_no_evict, i_clk, i_rst_n, o_out_valid && o_is_duplicate,
        !o_evicted_live, "eviction reported for a duplicate")
    `PDHW_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !mem_we,
        "table written while idle")
    `PDHW_ASSERT_NXT(a_finish_after_last, i_clk, i_rst_n,
        r_state == ST_SWEEP && r_ev_valid && r_ev_idx == AW'(TABLE_DEPTH - 1),
        r_state == ST_FINISH, "sweep did not end after the last slot")

endmodule

/* hw/rtl/pdhw_table.sv */
// Entry store of the duplicate filter: one write port, one registered read port.
// Depends on pdhw_pkg for the entry type.
module pdhw_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  pdhw_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output pdhw_pkg::t_entry  o_rdata
);

    pdhw_pkg::t_entry r_mem [TABLE_DEPTH];
    pdhw_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pdhw_cmp.sv */
// Shared age and hash compare unit, used once per slot during a table sweep.
// Depends on pdhw_pkg for the entry and result types.
module pdhw_cmp (
    input  pdhw_pkg::t_entry   i_entry,
    input  logic               i_written,
    input  logic [31:0]        i_now_ms,
    input  logic [31:0]        i_window,
    input  logic [31:0]        i_key,
    output pdhw_pkg::t_cmp_res o_res
);

    logic        live_in;
    logic [31:0] age;

    // A slot never written holds no meaningful data, so it counts as empty.
    assign live_in = i_entry.live && i_written;
    assign age     = i_now_ms - i_entry.stamp;

    always_comb begin
        o_res.expire     = live_in && (age > i_window);
        o_res.live_after = live_in && !o_res.expire;
        o_res.match      = o_res.live_after && (i_entry.hash == i_key);
    end

endmodule

/* dv/tb_packet_dedup_hash_window_top.sv */
// Self-checking testbench for the djb2 duplicate filter with its timed ring of hashes.
// Depends on pdhw_pkg and packet_dedup_hash_window_top; a built-in predictor checks every
// verdict.
`timescale 1ns / 1ps

module tb_packet_dedup_hash_window_top;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] now;
    } t_byte_beat;

    typedef struct packed {
        logic dup;
        logic evicted;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_byte_beat  in_beat = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_ready;
    logic        out_valid;
    logic        is_duplicate;
    logic        evicted_live;

    // Predictor state
    logic [31:0] window_ms;
    logic [31:0] fold_hash;
    logic [31:0] slot_hash  [DEPTH];
    logic [31:0] slot_stamp [DEPTH];
    logic        slot_live  [DEPTH];
    int          ring_slot;

    t_byte_beat  pending_beats [$];
    t_verdict    expected_verdicts [$];
    t_byte_beat  beat_next;
    t_verdict    verdict_want;
    int          beats_queued = 0;
    int          beats_taken = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    logic        calm;

    // Recently sent short packets, replayed to provoke duplicates.
    logic [63:0] pool_data [POOL_SIZE];
    int          pool_len  [POOL_SIZE];
    int          pool_fill = 0;
    int          pool_wr = 0;
    logic [31:0] traffic_ms;

    packet_dedup_hash_window_top #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_data_byte   (in_beat.data),
        .i_last_byte   (in_beat.last),
        .i_now_ms      (in_beat.now),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_is_duplicate(is_duplicate),
        .o_evicted_live(evicted_live),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    assign calm = (cycle_count >= 1500) && (cycle_count < 3500);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void predict_verdict(input t_byte_beat b);
        logic [31:0] h;
        logic [31:0] age;
        t_verdict    v;
        h = (fold_hash << 5) + fold_hash + {24'd0, b.data};
        if (!b.last) begin
            fold_hash = h;
            return;
        end
        fold_hash = pdhw_pkg::HASH_SEED;
        for (int i = 0; i < DEPTH; i++) begin
            age = b.now - slot_stamp[i];
            if (slot_live[i] && age > window_ms) begin
                slot_live[i] = 1'b0;
            end
        end
        v = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_live[i] && slot_hash[i] == h) begin
                v.dup = 1'b1;
            end
        end
        // Only a new hash is stored; the head slot is overwritten even if another slot is free.
        if (!v.dup) begin
            v.evicted = slot_live[ring_slot];
            slot_hash[ring_slot]  = h;
            slot_stamp[ring_slot] = b.now;
            slot_live[ring_slot]  = 1'b1;
            ring_slot = (ring_slot + 1) % DEPTH;
        end
        expected_verdicts.insert(expected_verdicts.size(), v);
    endfunction

    // Driver: a beat stays on the bus until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_verdict(in_beat);
                beats_taken++;
            end
            if (!in_valid || in_ready) begin
                if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
                    beat_next = pending_beats.pop_front();
                    in_beat  <= beat_next;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each verdict beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected verdict: dup=%0b evicted=%0b", is_duplicate,
                                 evicted_live);
                    end
                    mismatches++;
                end else begin
                    verdict_want = expected_verdicts.pop_front();
                    if (is_duplicate !== verdict_want.dup
                            || evicted_live !== verdict_want.evicted) begin
                        if (mismatches < 10) begin
                            $display("Mismatch: want dup=%0b ev=%0b, got dup=%0b ev=%0b",
                                     verdict_want.dup, verdict_want.evicted, is_duplicate,
                                     evicted_live);
                        end
                        mismatches++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic push_packet(input int len, input logic [63:0] payload,
                               input logic [31:0] stamp);
        t_byte_beat b;
        for (int i = 0; i < len; i++) begin
            b.data = (i < 8) ? payload[8*i +: 8] : 8'($urandom);
            b.last = (i == len - 1);
            b.now  = b.last ? stamp : $urandom;
            pending_beats.insert(pending_beats.size(), b);
            beats_queued++;
        end
    endtask

    task automatic gen_traffic(input int beats_wanted, input logic [31:0] step_max);
        int          sent;
        int          len;
        int          roll;
        int          pick;
        logic [63:0] payload;
        sent = 0;
        while (sent < beats_wanted) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                traffic_ms = traffic_ms - $urandom_range(0, step_max);
            end else if (roll < 10) begin
                traffic_ms = traffic_ms + $urandom;
            end else begin
                traffic_ms = traffic_ms + $urandom_range(0, step_max);
            end
            if (pool_fill != 0 && $urandom_range(0, 99) < 40) begin
                pick = $urandom_range(0, pool_fill - 1);
                len = pool_len[pick];
                payload = pool_data[pick];
            end else begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 40);
                payload = {$urandom, $urandom};
                if (len <= 8) begin
                    pool_data[pool_wr] = payload;
                    pool_len[pool_wr] = len;
                    pool_wr = (pool_wr + 1) % POOL_SIZE;
                    if (pool_fill < POOL_SIZE) begin
                        pool_fill++;
                    end
                end
            end
            push_packet(len, payload, traffic_ms);
            sent += len;
        end
    endtask

    // Waits until every beat is taken and every verdict seen, then lets the sweep finish.
    task automatic settle();
        while (beats_taken != beats_queued || expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DEPTH + 4) @(negedge i_clk);
    endtask

    task automatic set_window(input logic [31:0] ms);
        settle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ms;
        window_ms = ms;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [31:0] rand_window;
        window_ms = pdhw_pkg::WINDOW_RESET;
        fold_hash = pdhw_pkg::HASH_SEED;
        ring_slot = 0;
        for (int i = 0; i < DEPTH; i++) begin
            slot_live[i]  = 1'b0;
            slot_hash[i]  = '0;
            slot_stamp[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of 25000 ms: wrapped ages, the expiry boundary and replays.
        push_packet(1, 64'h00, 32'hFFFF_FFF0);
        push_packet(1, 64'h00, 32'd10);
        push_packet(1, 64'hFF, 32'd20);
        push_packet(3, 64'h3C5AA5, 32'd30);
        push_packet(3, 64'h3C5AA5, 32'd40);
        push_packet(1, 64'h00, 32'd24985);
        push_packet(1, 64'hFF, 32'd24985);
        push_packet(1, 64'h00, 32'd49985);
        push_packet(4, 64'hFFFF_FFFF, 32'd49985);
        traffic_ms = 32'd49985;

        gen_traffic(215, 32'd2000);
        set_window(32'd0);
        gen_traffic(215, 32'd1);
        set_window(32'hFFFF_FFFF);
        gen_traffic(215, 32'hFFFF_FFFF);
        set_window(32'd100);
        gen_traffic(215, 32'd30);
        rand_window = $urandom;
        set_window(rand_window);
        gen_traffic(215, (rand_window >> 3) + 32'd1);
        set_window(32'd1);
        gen_traffic(215, 32'd1);

        settle();
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pdhw_pkg.sv
hw/rtl/pdhw_table.sv
hw/rtl/pdhw_cmp.sv
hw/rtl/packet_dedup_hash_window_top.sv
dv/tb_packet_dedup_hash_window_top.sv
